>>> sv/pcpa_pkg.sv
// Shared types and constants for the per-CPU page allocator.
// No dependencies; imported by every module of the block except pcpa_ram.
`timescale 1ns / 1ps
`default_nettype none

package pcpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int CPU_W      = 3;
    localparam int PAGE_SHIFT = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 40;

    localparam logic [ADDR_W-1:0] MEM_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 32'h8800_0000;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_STOP  = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // classified request kinds carried from front to back
    typedef enum logic [KIND_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REJECT = 2'd2,
        OP_EMPTY  = 2'd3
    } op_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_POP  = 1'b1
    } back_state_t;

endpackage : pcpa_pkg

`default_nettype wire

>>> sv/pcpa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : pcpa_ram

`default_nettype wire

>>> sv/pcpa_queue.sv
// Two-entry request queue between the front classifier and the back executor.
// Depends on pcpa_pkg for the house style only.
`timescale 1ns / 1ps
`default_nettype none

module pcpa_queue
    import pcpa_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : pcpa_queue

`default_nettype wire

>>> sv/pcpa_front.sv
// Front end: takes requests, checks free addresses and CPU range, classifies.
// Depends on pcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpa_front
    import pcpa_pkg::*;
#(
    parameter int CPUS  = 8,
    parameter int PAGES = 32768
) (
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tuser,
    input  wire logic [S_DATA_W-1:0]       s_tdata,
    input  wire logic                      q_full,
    input  wire logic [ADDR_W-1:0]         mem_start,
    input  wire logic [ADDR_W-1:0]         mem_stop,
    input  wire logic [ADDR_W:0]           base,
    output logic                           s_tready,
    output logic                           push,
    output op_kind_t                       kind,
    output logic [$clog2(CPUS)-1:0]        cpu_idx,
    output logic [$clog2(PAGES)-1:0]       page
);

    localparam int CW = $clog2(CPUS);
    localparam int PW = $clog2(PAGES);
    localparam int PN_W = ADDR_W - PAGE_SHIFT;

    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       cpu_ext;
    logic [ADDR_W-1:0] diff;
    logic [PN_W-1:0]   pnum;
    logic              cpu_ok;
    logic              addr_ok;

    assign cpu  = s_tdata[CPU_W-1:0];
    assign addr = s_tdata[CPU_W+ADDR_W-1:CPU_W];

    assign cpu_ext = 32'(cpu);
    assign cpu_ok  = (cpu_ext < 32'(CPUS));
    assign cpu_idx = cpu_ext[CW-1:0];

    assign diff = addr - base[ADDR_W-1:0];
    assign pnum = diff[ADDR_W-1:PAGE_SHIFT];
    assign page = pnum[PW-1:0];

    assign addr_ok = (addr[PAGE_SHIFT-1:0] == '0)
                  && (addr >= mem_start)
                  && (addr < mem_stop)
                  && ({1'b0, addr} >= base)
                  && ({1'b0, pnum} < (PN_W+1)'(PAGES));

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        if (s_tuser == FUNC_FREE) begin
            kind = (cpu_ok && addr_ok) ? OP_FREE : OP_REJECT;
        end else begin
            kind = cpu_ok ? OP_ALLOC : OP_EMPTY;
        end
    end

endmodule : pcpa_front

`default_nettype wire

>>> sv/pcpa_back.sv
// Back end: per-CPU list heads, link memory, pop/push/steal and result register.
// Depends on pcpa_pkg and pcpa_ram.
`timescale 1ns / 1ps
`default_nettype none

module pcpa_back
    import pcpa_pkg::*;
#(
    parameter int CPUS  = 8,
    parameter int PAGES = 32768
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire op_kind_t                    q_kind,
    input  wire logic [$clog2(CPUS)-1:0]     q_cpu,
    input  wire logic [$clog2(PAGES)-1:0]    q_page,
    output logic                             q_pop,
    input  wire logic [ADDR_W-1:0]           base_lo,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [STATUS_W-1:0]              m_tuser,  // status
    output logic [ADDR_W-1:0]                m_tdata   // page_address
);

    localparam int CW = $clog2(CPUS);
    localparam int PW = $clog2(PAGES);

    back_state_t       state_reg, state_next;
    logic [PW-1:0]     head_page_reg  [CPUS];
    logic [CPUS-1:0]   head_valid_reg;
    logic [CW-1:0]     src_reg, src_next;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_load;

    logic              head_we;
    logic [CW-1:0]     head_wr_idx;
    logic [PW-1:0]     head_wr_page;
    logic              head_wr_valid;

    logic              link_we;
    logic [PW:0]       link_wdata;
    logic [PW-1:0]     link_raddr;
    logic [PW:0]       link_rdata;

    logic              slot_free;
    logic              found;
    logic [CW-1:0]     src;
    logic [PW-1:0]     popped_page;

    // link entry: {valid, next page}
    pcpa_ram #(
        .WIDTH (PW + 1),
        .DEPTH (PAGES)
    ) u_links (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (q_page),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    assign slot_free  = !out_valid_reg || m_tready;
    assign link_wdata = {head_valid_reg[q_cpu], head_page_reg[q_cpu]};
    assign popped_page = head_page_reg[src_reg];

    // own list first, otherwise lowest other non-empty list
    always_comb begin
        found = head_valid_reg[q_cpu];
        src   = q_cpu;
        for (int c = 0; c < CPUS; c++) begin
            if (!found && (CW'(c) != q_cpu) && head_valid_reg[c]) begin
                found = 1'b1;
                src   = CW'(c);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        src_next        = src_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;
        out_status_next = ST_OK;
        out_addr_next   = '0;
        head_we         = 1'b0;
        head_wr_idx     = q_cpu;
        head_wr_page    = q_page;
        head_wr_valid   = 1'b1;
        link_we         = 1'b0;
        link_raddr      = head_page_reg[src];
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && slot_free) begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    case (q_kind)
                        OP_FREE: begin
                            link_we = 1'b1;
                            head_we = 1'b1;
                        end
                        OP_ALLOC: begin
                            if (found) begin
                                out_load   = 1'b0;
                                src_next   = src;
                                state_next = BK_POP;
                            end else begin
                                out_status_next = ST_EMPTY;
                            end
                        end
                        OP_REJECT: out_status_next = ST_REJECT;
                        OP_EMPTY:  out_status_next = ST_EMPTY;
                        default:   out_status_next = ST_EMPTY;
                    endcase
                end
            end
            BK_POP: begin
                out_load      = 1'b1;
                out_addr_next = base_lo + (ADDR_W'(popped_page) << PAGE_SHIFT);
                head_we       = 1'b1;
                head_wr_idx   = src_reg;
                head_wr_page  = link_rdata[PW-1:0];
                head_wr_valid = link_rdata[PW];
                state_next    = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            head_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (head_we) begin
                head_valid_reg[head_wr_idx] <= head_wr_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        if (head_we) begin
            head_page_reg[head_wr_idx] <= head_wr_page;
        end
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_addr_reg;

endmodule : pcpa_back

`default_nettype wire

>>> sv/per_cpu_page_allocator.sv
// Per-CPU LIFO page allocator with stealing: each CPU has a free list of 4 KiB pages
// kept as a head register per CPU and a link memory indexed by page number. A free
// request pushes a checked page onto the caller's list; an alloc request pops the
// caller's head, or steals the head of the lowest-numbered other non-empty list.
// Every request gives one result (status in m_tuser, page address in m_tdata).
// Frees, rejects and empty allocs complete in the back end's idle state; a successful
// alloc moves on to a pop state: the link memory read is registered, and the pop state
// does the head update. A two-entry queue decouples request intake from execution; a
// result waiting on m_tready holds the back end, and the queue takes two more requests
// before s_tready drops. Lists are empty after reset; the link memory needs no
// clearing pass. Configuration writes (cfg_index 0 mem_start, 1 mem_stop) are taken
// every cycle.
// Depends on pcpa_pkg, pcpa_front, pcpa_queue, pcpa_back, pcpa_ram.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_page_allocator
    import pcpa_pkg::*;
#(
    parameter int CPUS  = 8,
    parameter int PAGES = 32768
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // cpu[2:0], address[34:3], zero pad
    input  wire logic                  s_tuser,   // func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [ADDR_W-1:0]          m_tdata,   // page_address[31:0]
    output logic [STATUS_W-1:0]        m_tuser,   // status[1:0]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ADDR_W-1:0]     cfg_data
);

    localparam int CW   = $clog2(CPUS);
    localparam int PW   = $clog2(PAGES);
    localparam int QW   = KIND_W + CW + PW;

    logic [ADDR_W-1:0] mem_start_reg;
    logic [ADDR_W-1:0] mem_stop_reg;
    logic [ADDR_W:0]   base_reg;
    logic [ADDR_W:0]   base_sum;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    op_kind_t          f_kind;
    logic [CW-1:0]     f_cpu;
    logic [PW-1:0]     f_page;

    assign cfg_ready = 1'b1;
    assign base_sum  = {1'b0, cfg_data} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_start_reg <= MEM_START_RST;
            mem_stop_reg  <= MEM_STOP_RST;
            base_reg      <= {1'b0, MEM_START_RST};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MEM_START: begin
                    mem_start_reg <= cfg_data;
                    base_reg      <= {base_sum[ADDR_W:PAGE_SHIFT], PAGE_SHIFT'(0)};
                end
                REG_MEM_STOP: mem_stop_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pcpa_front #(
        .CPUS  (CPUS),
        .PAGES (PAGES)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .mem_start (mem_start_reg),
        .mem_stop  (mem_stop_reg),
        .base      (base_reg),
        .s_tready  (s_tready),
        .push      (q_push),
        .kind      (f_kind),
        .cpu_idx   (f_cpu),
        .page      (f_page)
    );

    assign q_wdata = {f_kind, f_cpu, f_page};

    pcpa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    pcpa_back #(
        .CPUS  (CPUS),
        .PAGES (PAGES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_kind   (op_kind_t'(q_rdata[QW-1:CW+PW])),
        .q_cpu    (q_rdata[CW+PW-1:PW]),
        .q_page   (q_rdata[PW-1:0]),
        .q_pop    (q_pop),
        .base_lo  (base_reg[ADDR_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule : per_cpu_page_allocator

`default_nettype wire
